[rtl/pbrd_pkg.sv]
// ----------------------------------------------------------------------------
// pbrd_pkg
// Shared types and constants for the run-length row decoder.
// ----------------------------------------------------------------------------
package pbrd_pkg;

	localparam int DIM_W = 11;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam logic [DIM_W-1:0] WIDTH_RST = 11'd320;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd200;
	localparam logic [DIM_W-1:0] DIM_SAT = 11'h7ff;

	// register indexes
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// decode phases
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_RUN = 2'd1;
	localparam logic [1:0] PH_LITERAL = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	localparam logic [7:0] HDR_NOOP = 8'h80;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} cfg_t;

endpackage

[rtl/pbrd_regs.sv]
// ----------------------------------------------------------------------------
// pbrd_regs
// APB register file: image width and image height.
// ----------------------------------------------------------------------------
module pbrd_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pbrd_pkg::ADDR_W-1:0]   paddr,
	input  logic [pbrd_pkg::DATA_W-1:0]   pwdata,
	output logic [pbrd_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output pbrd_pkg::cfg_t                cfg
);

	logic [pbrd_pkg::DIM_W-1:0] width_q;
	logic [pbrd_pkg::DIM_W-1:0] height_q;
	logic                       wr_en;
	logic                       reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= pbrd_pkg::WIDTH_RST;
			height_q <= pbrd_pkg::HEIGHT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				pbrd_pkg::REG_WIDTH: width_q <= pwdata[pbrd_pkg::DIM_W-1:0];
				pbrd_pkg::REG_HEIGHT: height_q <= pwdata[pbrd_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			pbrd_pkg::REG_WIDTH: prdata[pbrd_pkg::DIM_W-1:0] = width_q;
			pbrd_pkg::REG_HEIGHT: prdata[pbrd_pkg::DIM_W-1:0] = height_q;
			default: prdata = '0;
		endcase
	end

	assign cfg.width = width_q;
	assign cfg.height = height_q;

endmodule

[rtl/pbrd_decode.sv]
// ----------------------------------------------------------------------------
// pbrd_decode
// Input register, combinational decode step over the stream state, and
// result register.
// ----------------------------------------------------------------------------
module pbrd_decode #(
	parameter int MAX_WIDTH = pbrd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = pbrd_pkg::MAX_HEIGHT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pbrd_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     data_byte,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     pixel_value,
	output logic [7:0]     repeat_count,
	output logic           row_end,
	output logic           image_end
);

	localparam int DW = pbrd_pkg::DIM_W;
	localparam logic [DW+1:0] LIM_W = (DW+2)'(MAX_WIDTH);
	localparam logic [DW+1:0] LIM_H = (DW+2)'(MAX_HEIGHT);

	// input stage
	logic          valid_s1;
	logic [7:0]    byte_s1;

	// stream state
	logic [1:0]    phase_q;
	logic [6:0]    lit_left_q;
	logic [7:0]    run_len_q;
	logic [DW-1:0] col_q;
	logic [DW-1:0] row_q;

	// result register
	logic          out_valid_q;
	logic [7:0]    pix_q;
	logic [7:0]    cnt_q;
	logic          row_end_q;
	logic          img_end_q;

	logic          has_res;
	logic          chunk_done;
	logic [7:0]    res_cnt;
	logic          out_free;
	logic          consume;
	logic          accept;
	logic [DW-1:0] w_eff;
	logic [DW-1:0] h_eff;
	logic [DW:0]   col_sum;
	logic [DW-1:0] col_sat;
	logic [DW-1:0] row_inc;
	logic          do_row;
	logic          do_img;
	logic [8:0]    run_calc;

	always_comb begin
		if (cfg.width == '0)
			w_eff = DW'(1);
		else if ({2'b00, cfg.width} > LIM_W)
			w_eff = LIM_W[DW-1:0];
		else
			w_eff = cfg.width;
		if (cfg.height == '0)
			h_eff = DW'(1);
		else if ({2'b00, cfg.height} > LIM_H)
			h_eff = LIM_H[DW-1:0];
		else
			h_eff = cfg.height;
	end

	always_comb begin
		has_res = 1'b0;
		chunk_done = 1'b0;
		res_cnt = 8'd1;
		unique case (phase_q)
			pbrd_pkg::PH_RUN: begin
				has_res = 1'b1;
				chunk_done = 1'b1;
				res_cnt = run_len_q;
			end
			pbrd_pkg::PH_LITERAL: begin
				has_res = 1'b1;
				chunk_done = (lit_left_q == '0);
			end
			default: ;
		endcase
	end

	assign run_calc = 9'd257 - {1'b0, byte_s1};
	assign col_sum = {1'b0, col_q} + (DW+1)'(res_cnt);
	assign col_sat = col_sum[DW] ? pbrd_pkg::DIM_SAT : col_sum[DW-1:0];
	assign do_row = chunk_done && (col_sat >= w_eff);
	assign row_inc = (row_q == pbrd_pkg::DIM_SAT) ? row_q : row_q + DW'(1);
	assign do_img = do_row && (row_inc >= h_eff);

	assign out_free = !out_valid_q || !out_stall;
	assign consume = valid_s1 && (!has_res || out_free);
	assign in_stall = valid_s1 && !consume;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			byte_s1 <= data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pbrd_pkg::PH_HEADER;
			lit_left_q <= '0;
			run_len_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (consume) begin
			unique case (phase_q)
				pbrd_pkg::PH_HEADER: begin
					if (byte_s1 > pbrd_pkg::HDR_NOOP) begin
						run_len_q <= run_calc[7:0];
						phase_q <= pbrd_pkg::PH_RUN;
					end else if (byte_s1 < pbrd_pkg::HDR_NOOP) begin
						lit_left_q <= byte_s1[6:0];
						phase_q <= pbrd_pkg::PH_LITERAL;
					end
				end
				pbrd_pkg::PH_RUN, pbrd_pkg::PH_LITERAL: begin
					if (phase_q == pbrd_pkg::PH_LITERAL && !chunk_done)
						lit_left_q <= lit_left_q - 7'd1;
					if (do_img)
						phase_q <= pbrd_pkg::PH_DONE;
					else if (chunk_done)
						phase_q <= pbrd_pkg::PH_HEADER;
					if (do_row) begin
						col_q <= '0;
						row_q <= row_inc;
					end else begin
						col_q <= col_sat;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && has_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && has_res) begin
			pix_q <= byte_s1;
			cnt_q <= res_cnt;
			row_end_q <= do_row;
			img_end_q <= do_img;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_value = pix_q;
	assign repeat_count = cnt_q;
	assign row_end = row_end_q;
	assign image_end = img_end_q;

endmodule

[rtl/packbits_row_decoder_top.sv]
// ----------------------------------------------------------------------------
// packbits_row_decoder_top
// Run-length image stream decoder: one compressed byte per request, one
// pixel/repeat result per value byte, with row and image end flags.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  input    | in_valid / in_stall       | data_byte
//  output   | out_valid / out_stall     | pixel_value, repeat_count,
//           |                           | row_end, image_end
//  config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One byte per cycle sustained while out_stall is low; a taken byte passes
// the input register, then the decode step into the result register, where
// its result is presented.
// Reset clears the stream state and loads width 320, height 200.
// A stalled result holds; the input register keeps taking bytes that give
// no result, and stalls only when its byte needs the occupied result slot.
// After the last row every byte is taken and dropped until reset.
// ----------------------------------------------------------------------------
module packbits_row_decoder_top #(
	parameter int MAX_WIDTH = pbrd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = pbrd_pkg::MAX_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pbrd_pkg::ADDR_W-1:0]  paddr,
	input  logic [pbrd_pkg::DATA_W-1:0]  pwdata,
	output logic [pbrd_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   data_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   pixel_value,
	output logic [7:0]                   repeat_count,
	output logic                         row_end,
	output logic                         image_end
);

	pbrd_pkg::cfg_t cfg;

	pbrd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pbrd_decode #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_value  (pixel_value),
		.repeat_count (repeat_count),
		.row_end      (row_end),
		.image_end    (image_end)
	);

endmodule
